// ===== rtl/x87rs_pkg.sv =====
`default_nettype none

package x87rs_pkg;

  // Geometry of the register stack.
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned PTR_W       = 3;
  localparam int unsigned MANT_W      = 64;
  localparam int unsigned SEXP_W      = 16;
  localparam int unsigned ENTRY_W     = MANT_W + SEXP_W;
  localparam int unsigned STATUS_W    = 16;
  localparam int unsigned CC_W        = 4;

  // Placement of fields in the status word.
  localparam int unsigned C3_BIT_POS = 14;
  localparam int unsigned TOP_SHIFT  = 11;
  localparam int unsigned CC_LO_POS  = 8;

  // Beat widths on the two stream channels.
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned M_TDATA_W = 96;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ERR_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SETCC  = 3'd4,
    OP_STATUS = 3'd5
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Request from the controller to the entry memory.
  typedef struct packed {
    logic               re;
    logic [PTR_W-1:0]   raddr;
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  // Assemble the status word from the top pointer and condition code.
  function automatic logic [STATUS_W-1:0] make_status(input logic [PTR_W-1:0] top,
                                                      input logic [CC_W-1:0] cc);
    logic [STATUS_W-1:0] s;
    s = '0;
    s[C3_BIT_POS] = cc[3];
    s[TOP_SHIFT +: PTR_W] = top;
    s[CC_LO_POS +: 3] = cc[2:0];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/x87rs_regfile.sv =====
`default_nettype none

module x87rs_regfile (
  input  wire logic                       clk,
  input  wire x87rs_pkg::mem_req_t        req,
  output logic [x87rs_pkg::ENTRY_W-1:0]   rdata
);
  import x87rs_pkg::*;

  logic [ENTRY_W-1:0] mem [STACK_DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/x87rs_ctrl.sv =====
`default_nettype none

module x87rs_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [x87rs_pkg::OP_W-1:0]     s_tuser,
  input  wire logic [x87rs_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [x87rs_pkg::ERR_W-1:0]         m_tuser,
  output logic [x87rs_pkg::M_TDATA_W-1:0]     m_tdata,
  output x87rs_pkg::mem_req_t                 mem_req,
  input  wire logic [x87rs_pkg::ENTRY_W-1:0]  mem_rdata
);
  import x87rs_pkg::*;

  state_t state, state_next;

  logic [STACK_DEPTH-1:0] valid;
  logic [PTR_W-1:0]       top;
  logic [CC_W-1:0]        cc;

  logic [OP_W-1:0]     op_q;
  logic [PTR_W-1:0]    slot_q;
  logic [ENTRY_W-1:0]  value_q;
  logic [STATUS_W-1:0] status_in_q;

  logic                in_fire;
  logic                out_free;
  logic                done;
  logic [PTR_W-1:0]    in_index;
  logic [PTR_W-1:0]    in_slot;
  logic                slot_valid;

  logic [PTR_W-1:0]    top_new;
  logic [CC_W-1:0]     cc_new;
  logic                set_valid;
  logic                clr_valid;
  logic                wr_entry;
  logic                give_value;
  err_t                err;

  assign in_index = s_tdata[PTR_W-1:0];
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == ST_EXEC) && out_free;

  // Entry addressed by the incoming beat, from the current top pointer.
  always_comb begin
    case (op_t'(s_tuser))
      OP_PUSH: in_slot = top - PTR_W'(1);
      OP_POP:  in_slot = top;
      default: in_slot = top + in_index;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake output of the state machine.
  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the beat; the memory read is issued in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q        <= s_tuser;
      slot_q      <= in_slot;
      value_q     <= {s_tdata[PTR_W+MANT_W +: SEXP_W], s_tdata[PTR_W +: MANT_W]};
      status_in_q <= s_tdata[PTR_W+MANT_W+SEXP_W +: STATUS_W];
    end
  end

  assign slot_valid = valid[slot_q];

  // Decode the operation against the valid bits and the pointer.
  always_comb begin
    top_new    = top;
    cc_new     = cc;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    wr_entry   = 1'b0;
    give_value = 1'b0;
    err        = ERR_OK;
    case (op_q)
      OP_PUSH: begin
        if (slot_valid) begin
          err = ERR_FULL;
        end else begin
          top_new   = slot_q;
          set_valid = 1'b1;
          wr_entry  = 1'b1;
        end
      end
      OP_POP: begin
        if (!slot_valid) begin
          err = ERR_EMPTY;
        end else begin
          give_value = 1'b1;
          clr_valid  = 1'b1;
          top_new    = slot_q + PTR_W'(1);
        end
      end
      OP_READ: begin
        if (!slot_valid) begin
          err = ERR_EMPTY;
        end else begin
          give_value = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!slot_valid) begin
          err = ERR_EMPTY;
        end else begin
          wr_entry = 1'b1;
        end
      end
      OP_SETCC: begin
        cc_new = {status_in_q[C3_BIT_POS], status_in_q[CC_LO_POS +: 3]};
      end
      default: begin
      end
    endcase
  end

  // Memory request: read on accept, write back when the operation retires.
  always_comb begin
    mem_req.re    = in_fire;
    mem_req.raddr = in_slot;
    mem_req.we    = done && wr_entry;
    mem_req.waddr = slot_q;
    mem_req.wdata = value_q;
  end

  // Architectural state commits when the result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      top   <= '0;
      cc    <= '0;
    end else if (done) begin
      top <= top_new;
      cc  <= cc_new;
      if (set_valid) begin
        valid[slot_q] <= 1'b1;
      end
      if (clr_valid) begin
        valid[slot_q] <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tuser <= err;
      m_tdata <= {make_status(top_new, cc_new),
                  give_value ? mem_rdata : ENTRY_W'(0)};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/x87_register_stack_top.sv =====
// x87 register stack: eight 80-bit entries addressed relative to a top pointer.
// Input channel s_*: one beat is one operation. s_tuser carries the op code
// (push, pop, read st(i), write st(i), set condition code, read status);
// s_tdata carries the index, the 80-bit value and a status word.
// Output channel m_*: exactly one result beat per operation, in order. It holds
// the value read or popped (zero otherwise), the status word after the
// operation, and in m_tuser an error code (empty entry or occupied push slot).
// The entries live in a synchronous memory read on accept and written back
// when the operation retires, so one operation is in flight at a time and a
// new beat is not taken until the previous result is loaded.
// s_tready is high whenever no operation is in flight, even while a result
// waits in the output register; a stalled receiver holds the operation in its
// execute state and thereby blocks further input.
// Reset (rst, synchronous) clears all valid bits, the top pointer and the
// condition code; entry data is not cleared and is read only once pushed.
`default_nettype none

module x87_register_stack_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // s_tuser: op[2:0]
  input  wire logic [2:0]    s_tuser,
  // s_tdata: index[2:0], value_mantissa[66:3], value_sign_exponent[82:67],
  //          status_in[98:83], zero pad[103:99]
  input  wire logic [103:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // m_tuser: error[1:0]
  output logic [1:0]         m_tuser,
  // m_tdata: out_mantissa[63:0], out_sign_exponent[79:64], status_word[95:80]
  output logic [95:0]        m_tdata
);
  import x87rs_pkg::*;

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  x87rs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  x87rs_regfile u_regfile (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/x87rs_checker.sv =====
`default_nettype none

module x87rs_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [1:0]   m_tuser,
  input wire logic [95:0]  m_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready
);

  // One operation in flight: no beat is taken right after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input beat accepted while an operation is in flight");

  // A failed operation never returns a value.
  a_err_no_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != 2'd0) |-> (m_tdata[79:0] == 80'd0))
    else $error("value returned with an error code");

  // Unused bits of the status word stay zero.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[95] == 1'b0 && m_tdata[87:80] == 8'd0))
    else $error("reserved status bits set");

  // Only the defined error codes appear.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("undefined error code");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result dropped or changed under stall");

endmodule

bind x87_register_stack_top x87rs_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire

// ===== bench/tb_x87_register_stack_top.sv =====
`timescale 1ns / 1ps

module tb_x87_register_stack_top;
  import x87rs_pkg::*;

  // Op codes that the block does not define; they must leave the state alone.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [63:0] MANT_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_PER_PHASE = 542;
  localparam int LONG_STALL = 200;
  localparam int DRAIN_CYCLES = 8;

  // One result beat as the checker sees it.
  typedef struct packed {
    logic [63:0] mant;
    logic [15:0] sexp;
    logic [15:0] status;
    err_t        err;
  } stack_result_t;

  // One operation beat, with an optional result that is known up front.
  typedef struct {
    logic [2:0]    op;
    logic [2:0]    idx;
    logic [63:0]   mant;
    logic [15:0]   sexp;
    logic [15:0]   status_in;
    bit            known;
    stack_result_t want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [2:0]    s_tuser = '0;
  logic [103:0]  s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [1:0]    m_tuser;
  logic [95:0]   m_tdata;

  // Mirror of the register stack used for prediction.
  logic [63:0] slot_mant [8];
  logic [15:0] slot_sexp [8];
  bit          slot_full [8] = '{default: 1'b0};
  logic [2:0]  stack_top = 3'd0;
  logic [3:0]  cond_code = 4'd0;

  stack_result_t pending_results [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  x87_register_stack_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the mirror and work out the beat it should give.
  function automatic stack_result_t apply_stack_op(input stim_row_t r);
    stack_result_t res;
    logic [2:0]    slot;
    res = '{mant: '0, sexp: '0, status: '0, err: ERR_OK};
    case (r.op)
      OP_PUSH: begin
        slot = stack_top - 3'd1;
        if (slot_full[slot]) begin
          res.err = ERR_FULL;
        end else begin
          stack_top = slot;
          slot_full[slot] = 1'b1;
          slot_mant[slot] = r.mant;
          slot_sexp[slot] = r.sexp;
        end
      end
      OP_POP: begin
        slot = stack_top;
        if (!slot_full[slot]) begin
          res.err = ERR_EMPTY;
        end else begin
          res.mant = slot_mant[slot];
          res.sexp = slot_sexp[slot];
          slot_full[slot] = 1'b0;
          stack_top = slot + 3'd1;
        end
      end
      OP_READ, OP_WRITE: begin
        slot = stack_top + r.idx;
        if (!slot_full[slot]) begin
          res.err = ERR_EMPTY;
        end else if (r.op == OP_READ) begin
          res.mant = slot_mant[slot];
          res.sexp = slot_sexp[slot];
        end else begin
          slot_mant[slot] = r.mant;
          slot_sexp[slot] = r.sexp;
        end
      end
      OP_SETCC: cond_code = {r.status_in[14], r.status_in[10:8]};
      default: ;
    endcase
    // C3 at bit 14, top at 13:11, C2..C0 at 10:8.
    res.status = {1'b0, cond_code[3], stack_top, cond_code[2:0], 8'h00};
    return res;
  endfunction

  function automatic stim_row_t row(input logic [2:0] op, input logic [2:0] idx,
                                    input logic [63:0] mant, input logic [15:0] sexp,
                                    input logic [15:0] sin, input bit known = 1'b0,
                                    input logic [63:0] w_mant = '0,
                                    input logic [15:0] w_sexp = '0,
                                    input logic [15:0] w_status = '0,
                                    input err_t w_err = ERR_OK);
    stim_row_t r;
    r.op = op;
    r.idx = idx;
    r.mant = mant;
    r.sexp = sexp;
    r.status_in = sin;
    r.known = known;
    r.want = '{mant: w_mant, sexp: w_sexp, status: w_status, err: w_err};
    return r;
  endfunction

  // Random operation; pushes slightly outweigh pops so the stack moves
  // between empty and full, with reads and writes landing on live entries.
  function automatic stim_row_t random_op();
    int pick;
    int flavour;
    logic [2:0]  op;
    logic [63:0] mant;
    pick = $urandom_range(99);
    if (pick < 25) op = OP_PUSH;
    else if (pick < 47) op = OP_POP;
    else if (pick < 62) op = OP_READ;
    else if (pick < 77) op = OP_WRITE;
    else if (pick < 86) op = OP_SETCC;
    else if (pick < 94) op = OP_STATUS;
    else op = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    flavour = $urandom_range(15);
    if (flavour == 0) mant = MANT_ONES;
    else if (flavour == 1) mant = '0;
    else mant = {$urandom, $urandom};
    return row(op, 3'($urandom_range(7)), mant, 16'($urandom), 16'($urandom));
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one operation beat, with random idle cycles in front of it, and
  // record its expected result once the beat is taken.
  task automatic offer_op(input stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.op;
    s_tdata <= {5'b0, r.status_in, r.sexp, r.mant, r.idx};
    do @(posedge clk); while (!s_tready);
    if (r.known) begin
      void'(apply_stack_op(r));
      pending_results.push_back(r.want);
    end else begin
      pending_results.push_back(apply_stack_op(r));
    end
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      stall_left <= LONG_STALL;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected", m_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[63:0] !== want.mant)
          flag_mismatch("out_mantissa", m_tdata[63:0], want.mant);
        if (m_tdata[79:64] !== want.sexp)
          flag_mismatch("out_sign_exponent", 64'(m_tdata[79:64]), 64'(want.sexp));
        if (m_tdata[95:80] !== want.status)
          flag_mismatch("status_word", 64'(m_tdata[95:80]), 64'(want.status));
        if (m_tuser !== want.err)
          flag_mismatch("error", 64'(m_tuser), 64'(want.err));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t directed [$];
    stim_row_t r;
    int counted;

    // Empty stack straight after reset: every access to an entry is refused.
    directed.push_back(row(OP_STATUS, 3'd0, '0, '0, '0, 1, '0, '0, 16'h0000, ERR_OK));
    directed.push_back(row(OP_POP, 3'd0, '0, '0, '0, 1, '0, '0, 16'h0000, ERR_EMPTY));
    directed.push_back(row(OP_READ, 3'd7, MANT_ONES, 16'hFFFF, 16'hFFFF,
                           1, '0, '0, 16'h0000, ERR_EMPTY));
    directed.push_back(row(OP_WRITE, 3'd0, MANT_ONES, 16'hFFFF, '0,
                           1, '0, '0, 16'h0000, ERR_EMPTY));
    // Condition code from an all-ones word, then from one with only the other bits set.
    directed.push_back(row(OP_SETCC, 3'd0, '0, '0, 16'hFFFF, 1, '0, '0, 16'h4700, ERR_OK));
    directed.push_back(row(OP_SETCC, 3'd7, MANT_ONES, 16'hFFFF, 16'hB8FF,
                           1, '0, '0, 16'h0000, ERR_OK));
    // Push and pop the largest value.
    directed.push_back(row(OP_PUSH, 3'd0, MANT_ONES, 16'hFFFF, '0,
                           1, '0, '0, 16'h3800, ERR_OK));
    directed.push_back(row(OP_POP, 3'd0, '0, '0, '0,
                           1, MANT_ONES, 16'hFFFF, 16'h0000, ERR_OK));
    // Fill all eight entries, then push once too often.
    directed.push_back(row(OP_PUSH, 3'd0, '0, '0, '0));
    directed.push_back(row(OP_PUSH, 3'd1, 64'h0123_4567_89AB_CDEF, 16'h3FFF, '0));
    directed.push_back(row(OP_PUSH, 3'd2, 64'h8000_0000_0000_0000, 16'h8000, '0));
    directed.push_back(row(OP_PUSH, 3'd3, 64'h0000_0000_0000_0001, 16'h0001, '0));
    directed.push_back(row(OP_PUSH, 3'd4, 64'hDEAD_BEEF_CAFE_F00D, 16'hC00B, '0));
    directed.push_back(row(OP_PUSH, 3'd5, 64'h5555_5555_5555_5555, 16'h5555, '0));
    directed.push_back(row(OP_PUSH, 3'd6, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, '0));
    directed.push_back(row(OP_PUSH, 3'd7, MANT_ONES, 16'hFFFF, '0));
    directed.push_back(row(OP_PUSH, 3'd0, 64'h1111_2222_3333_4444, 16'h7777, '0,
                           1, '0, '0, 16'h0000, ERR_FULL));
    // Stack-relative reads and writes on a full stack.
    directed.push_back(row(OP_READ, 3'd7, '0, '0, '0));
    directed.push_back(row(OP_WRITE, 3'd3, 64'h0F0F_0F0F_F0F0_F0F0, 16'h0FF0, '0));
    directed.push_back(row(OP_READ, 3'd3, '0, '0, '0));
    // Spare op codes change nothing.
    directed.push_back(row(OP_SPARE_LO, 3'd7, MANT_ONES, 16'hFFFF, 16'hFFFF,
                           1, '0, '0, 16'h0000, ERR_OK));
    directed.push_back(row(OP_SPARE_HI, 3'd7, MANT_ONES, 16'hFFFF, 16'hFFFF,
                           1, '0, '0, 16'h0000, ERR_OK));
    directed.push_back(row(OP_SETCC, 3'd0, '0, '0, 16'h4000));
    directed.push_back(row(OP_STATUS, 3'd0, '0, '0, '0));
    directed.push_back(row(OP_POP, 3'd0, '0, '0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the first idling pattern.
    send_idle_pct = 34;
    recv_idle_pct <= 68;
    foreach (directed[k]) offer_op(directed[k]);

    // Random phases: sender-light, receiver-light, then flat out with a long hold-off.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct <= 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          stall_requests <= stall_requests + 1;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        r = random_op();
        offer_op(r);
        counted++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then give any stray beat time to appear.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
